// ----- sv/bf3_pkg.sv -----
package bf3_pkg;

	localparam int PIX_W       = 8;
	localparam int COL_W       = 6;
	localparam int ROW_W       = 12;
	localparam int LANES       = 3;
	localparam int LANE_W      = 2;
	localparam int WORD_W      = LANES * PIX_W;
	localparam int CSUM_W      = 10;
	localparam int SUM_W       = 12;
	localparam int DIV_MUL_W   = 13;
	localparam int PROD_W      = SUM_W + DIV_MUL_W + 1;
	localparam int DIV_SHIFT   = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 12;
	localparam int MAX_WIDTH_DEF = 32;

	localparam logic [DIV_MUL_W-1:0] DIV9_MUL = DIV_MUL_W'(7282);

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

	localparam logic [COL_W-1:0] WIDTH_RST  = COL_W'(7);
	localparam logic [ROW_W-1:0] HEIGHT_RST = ROW_W'(7);
	localparam logic [COL_W-1:0] WIDTH_MIN  = COL_W'(3);
	localparam logic [ROW_W-1:0] HEIGHT_MIN = ROW_W'(3);

	localparam logic [LANE_W-1:0] LANE0 = LANE_W'(0);
	localparam logic [LANE_W-1:0] LANE1 = LANE_W'(1);
	localparam logic [LANE_W-1:0] LANE2 = LANE_W'(2);

	typedef struct packed {
		logic [COL_W-1:0] width;
		logic [ROW_W-1:0] height;
	} cfg_t;

	function automatic logic [PIX_W-1:0] get_lane(input logic [WORD_W-1:0] word,
			input logic [LANE_W-1:0] idx);
		logic [PIX_W-1:0] res;
		case (idx)
			LANE0:   res = word[PIX_W-1:0];
			LANE1:   res = word[2*PIX_W-1:PIX_W];
			LANE2:   res = word[3*PIX_W-1:2*PIX_W];
			default: res = '0;
		endcase
		return res;
	endfunction

	function automatic logic [WORD_W-1:0] set_lane(input logic [WORD_W-1:0] word,
			input logic [LANE_W-1:0] idx, input logic [PIX_W-1:0] pix);
		logic [WORD_W-1:0] res;
		res = word;
		case (idx)
			LANE0:   res[PIX_W-1:0] = pix;
			LANE1:   res[2*PIX_W-1:PIX_W] = pix;
			LANE2:   res[3*PIX_W-1:2*PIX_W] = pix;
			default: res = word;
		endcase
		return res;
	endfunction

	function automatic logic [CSUM_W-1:0] col_sum(input logic [WORD_W-1:0] word);
		return CSUM_W'(word[PIX_W-1:0]) + CSUM_W'(word[2*PIX_W-1:PIX_W])
			+ CSUM_W'(word[3*PIX_W-1:2*PIX_W]);
	endfunction

	function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] sum);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(sum) * PROD_W'(DIV9_MUL);
		return prod[DIV_SHIFT+PIX_W-1:DIV_SHIFT];
	endfunction

	function automatic logic [LANE_W-1:0] lane_prev(input logic [LANE_W-1:0] idx);
		return (idx == LANE0) ? LANE2 : idx - LANE1;
	endfunction

	function automatic logic [LANE_W-1:0] lane_next(input logic [LANE_W-1:0] idx);
		return (idx == LANE2) ? LANE0 : idx + LANE1;
	endfunction

endpackage

// ----- sv/box_filter_3x3.sv -----
// a pixel may give no result, a border result or a filtered one
// a new pixel is taken only once the sequencer is idle again; the frame end flushes the last row
// the line store reads bound the pixel rate, at most one column word per cycle through one read port
// reset: counters, sequencer and output valid clear, width and height return to 7
// the line store is not cleared by reset
module box_filter_3x3
	import bf3_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  px_valid,
	output logic                  px_stall,
	input  logic [PIX_W-1:0]      pixel_in,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [PIX_W-1:0]      pixel_out,
	output logic                  run_last,
	output logic                  frame_end
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic [COL_W-1:0]  image_width_q;
	logic [ROW_W-1:0]  image_height_q;
	cfg_t              cfg;

	logic              mem_we;
	logic [COL_W-1:0]  mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              mem_re;
	logic [COL_W-1:0]  mem_raddr;
	logic [WORD_W-1:0] mem_rdata;

	// registers change only while no pixel is in work
	assign cfg_ready = !px_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RST;
			image_height_q <= HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WIDTH:  image_width_q  <= cfg_data[COL_W-1:0];
				CFG_HEIGHT: image_height_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp to the usable range
	always_comb begin
		if (image_width_q < WIDTH_MIN) begin
			cfg.width = WIDTH_MIN;
		end else if (image_width_q > COL_W'(MAX_WIDTH)) begin
			cfg.width = COL_W'(MAX_WIDTH);
		end else begin
			cfg.width = image_width_q;
		end
		cfg.height = (image_height_q < HEIGHT_MIN) ? HEIGHT_MIN : image_height_q;
	end

	bf3_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr[AW-1:0]),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr[AW-1:0]),
		.rdata (mem_rdata)
	);

	bf3_seq #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.px_valid  (px_valid),
		.px_stall  (px_stall),
		.pixel_in  (pixel_in),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.pixel_out (pixel_out),
		.run_last  (run_last),
		.frame_end (frame_end),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		px_valid && !px_stall |=> px_stall)
		else $error("pixel transfer did not start the store update");

	a_frame_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_end |-> run_last)
		else $error("frame end on a result that is not the last of its run");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(px_stall))
		else $error("result appeared without a pixel in work");

endmodule

// ----- sv/bf3_line_mem.sv -----
module bf3_line_mem
	import bf3_pkg::*;
#(
	parameter int DEPTH = MAX_WIDTH_DEF,
	parameter int AW    = $clog2(MAX_WIDTH_DEF)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/bf3_seq.sv -----
module bf3_seq
	import bf3_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              px_valid,
	output logic              px_stall,
	input  logic [PIX_W-1:0]  pixel_in,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [PIX_W-1:0]  pixel_out,
	output logic              run_last,
	output logic              frame_end,
	output logic              mem_we,
	output logic [COL_W-1:0]  mem_waddr,
	output logic [WORD_W-1:0] mem_wdata,
	output logic              mem_re,
	output logic [COL_W-1:0]  mem_raddr,
	input  logic [WORD_W-1:0] mem_rdata
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MERGE = 8'b0000_0010,
		S_COL1  = 8'b0000_0100,
		S_COL2  = 8'b0000_1000,
		S_EMIT1 = 8'b0001_0000,
		S_EMIT2 = 8'b0010_0000,
		S_FRD   = 8'b0100_0000,
		S_FEM   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [LANE_W-1:0] rmod_q;

	logic [PIX_W-1:0]  pix_q;
	logic [COL_W-1:0]  c_q;
	logic [LANE_W-1:0] rm_q;
	logic              row_end_q;
	logic              frame_last_q;
	logic              interior_q;
	logic              emit1_q;
	logic [WORD_W-1:0] merged_q;
	logic [WORD_W-1:0] col1_q;
	logic [SUM_W-1:0]  sum_q;
	logic [COL_W-1:0]  k_q;

	logic              res_valid_q;
	logic [PIX_W-1:0]  pixel_q;
	logic              run_last_q;
	logic              frame_end_q;

	logic              accept;
	logic              load_ok;
	logic              load;
	logic [PIX_W-1:0]  load_pix;
	logic              load_last;
	logic              load_fend;
	logic              row_end;
	logic              frame_last;
	logic              interior;
	logic [WORD_W-1:0] merged;
	logic              flush_last;

	assign accept  = (state_q == S_IDLE) && px_valid;
	assign px_stall = (state_q != S_IDLE);
	assign load_ok = !res_valid_q || !res_stall;

	assign row_end    = ({1'b0, col_q} + (COL_W+1)'(1)) >= {1'b0, cfg.width};
	assign frame_last = row_end && (({1'b0, row_q} + (ROW_W+1)'(1)) >= {1'b0, cfg.height});
	assign interior   = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2))
		&& (({1'b0, row_q} + (ROW_W+1)'(1)) <= {1'b0, cfg.height})
		&& (({1'b0, col_q} + (COL_W+1)'(1)) <= {1'b0, cfg.width});

	assign merged     = set_lane(mem_rdata, rm_q, pix_q);
	assign flush_last = ({1'b0, k_q} + (COL_W+1)'(1)) >= {1'b0, cfg.width};

	always_comb begin
		state_d   = state_q;
		mem_re    = 1'b0;
		mem_raddr = col_q;
		mem_we    = 1'b0;
		mem_waddr = c_q;
		mem_wdata = merged;
		load      = 1'b0;
		load_pix  = get_lane(col1_q, lane_prev(rm_q));
		load_last = 1'b0;
		load_fend = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (px_valid) begin
					mem_re  = 1'b1;
					state_d = S_MERGE;
				end
			end
			S_MERGE: begin
				mem_we    = c_q < COL_W'(MAX_WIDTH);
				mem_re    = emit1_q;
				mem_raddr = c_q - COL_W'(1);
				if (emit1_q) begin
					state_d = S_COL1;
				end else if (frame_last_q) begin
					state_d = S_FRD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_COL1: begin
				mem_re    = interior_q;
				mem_raddr = c_q - COL_W'(2);
				state_d   = interior_q ? S_COL2 : S_EMIT1;
			end
			S_COL2: begin
				state_d = S_EMIT1;
			end
			S_EMIT1: begin
				load      = load_ok;
				load_pix  = interior_q ? div9(sum_q) : get_lane(col1_q, lane_prev(rm_q));
				load_last = !row_end_q;
				if (load_ok) begin
					state_d = row_end_q ? S_EMIT2 : S_IDLE;
				end
			end
			S_EMIT2: begin
				load      = load_ok;
				load_pix  = get_lane(merged_q, lane_prev(rm_q));
				load_last = !frame_last_q;
				if (load_ok) begin
					state_d = frame_last_q ? S_FRD : S_IDLE;
				end
			end
			S_FRD: begin
				mem_re    = 1'b1;
				mem_raddr = k_q;
				state_d   = S_FEM;
			end
			S_FEM: begin
				load      = load_ok;
				load_pix  = get_lane(mem_rdata, rm_q);
				load_last = flush_last;
				load_fend = flush_last;
				if (load_ok) begin
					state_d = flush_last ? S_IDLE : S_FRD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			rmod_q      <= LANE0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (row_end) begin
					col_q  <= '0;
					row_q  <= frame_last ? '0 : row_q + ROW_W'(1);
					rmod_q <= frame_last ? LANE0 : lane_next(rmod_q);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q        <= pixel_in;
			c_q          <= col_q;
			rm_q         <= rmod_q;
			row_end_q    <= row_end;
			frame_last_q <= frame_last;
			interior_q   <= interior;
			emit1_q      <= (row_q != '0) && (col_q != '0);
			k_q          <= '0;
		end
		if (state_q == S_MERGE) begin
			merged_q <= merged;
		end
		if (state_q == S_COL1) begin
			col1_q <= mem_rdata;
		end
		if (state_q == S_COL2) begin
			sum_q <= SUM_W'(col_sum(merged_q)) + SUM_W'(col_sum(col1_q))
				+ SUM_W'(col_sum(mem_rdata));
		end
		if (state_q == S_FEM && load_ok && !flush_last) begin
			k_q <= k_q + COL_W'(1);
		end
		if (load) begin
			pixel_q     <= load_pix;
			run_last_q  <= load_last;
			frame_end_q <= load_fend;
		end
	end

	assign res_valid = res_valid_q;
	assign pixel_out = pixel_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

endmodule

// ----- bench/box_filter_3x3_tb.sv -----
module box_filter_3x3_tb;
	import bf3_pkg::*;

	localparam int WIN = 3;
	localparam int AREA = WIN * WIN;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  px_valid = 1'b0;
	logic                  px_stall;
	logic [PIX_W-1:0]      pixel_in = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic [PIX_W-1:0]      pixel_out;
	logic                  run_last;
	logic                  frame_end;

	box_filter_3x3 i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.px_valid (px_valid),
		.px_stall (px_stall),
		.pixel_in (pixel_in),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.pixel_out(pixel_out),
		.run_last (run_last),
		.frame_end(frame_end)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             last;
		logic             fend;
	} filt_res_t;

	typedef enum logic {STEP_REG, STEP_PIX} step_kind_t;

	typedef struct packed {
		step_kind_t            kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [PIX_W-1:0]      pix;
		logic [7:0]            count;
		logic                  toggle;
		logic                  typed;
	} step_t;

	step_t directed_tab [4] = '{
		// width stays at its reset value
		'{STEP_REG, CFG_HEIGHT, 12'd3, 8'd0, 8'd0, 1'b0, 1'b0},
		'{STEP_PIX, CFG_WIDTH, 12'd0, 8'd255, 8'd21, 1'b0, 1'b1},
		// zero width acts as the minimum
		'{STEP_REG, CFG_WIDTH, 12'd0, 8'd0, 8'd0, 1'b0, 1'b0},
		'{STEP_PIX, CFG_WIDTH, 12'd0, 8'd0, 8'd9, 1'b1, 1'b0}
	};

	filt_res_t filtered_q[$];
	filt_res_t head;
	logic [PIX_W-1:0]  line_copy [WIN][MAX_WIDTH_DEF];
	logic [COL_W-1:0]  col_pos = '0;
	logic [ROW_W-1:0]  row_pos = '0;
	logic [COL_W-1:0]  width_reg = WIDTH_RST;
	logic [ROW_W-1:0]  height_reg = HEIGHT_RST;
	int errors = 0;
	int send_gap_pct = 0;
	int stall_pct = 0;

	function automatic int unsigned eff_width();
		if (width_reg < WIDTH_MIN)
			return WIDTH_MIN;
		if (width_reg > MAX_WIDTH_DEF)
			return MAX_WIDTH_DEF;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;
	endfunction

	function automatic logic [PIX_W-1:0] out_value(input int unsigned r, input int unsigned c,
			input int unsigned w, input int unsigned h);
		int unsigned acc;
		acc = 0;
		if (r == 0 || r + 2 > h || c == 0 || c + 2 > w)
			return line_copy[r % WIN][c];
		for (int unsigned dr = 0; dr < WIN; dr++)
			for (int unsigned dc = 0; dc < WIN; dc++)
				acc += line_copy[(r - 1 + dr) % WIN][c - 1 + dc];
		return PIX_W'(acc / AREA);
	endfunction

	task automatic filter_pixel(input logic [PIX_W-1:0] pix, input logic [PIX_W-1:0] want,
			input bit typed);
		int unsigned w, h, r, c;
		bit row_end, frame_last;
		logic [PIX_W-1:0] vals[$];
		filt_res_t item;
		w = eff_width();
		h = eff_height();
		r = row_pos;
		c = col_pos;
		row_end = (c + 1 >= w);
		frame_last = row_end && (r + 1 >= h);
		line_copy[r % WIN][c] = pix;
		if (r >= 1 && c >= 1) begin
			vals.push_back(out_value(r - 1, c - 1, w, h));
			if (row_end)
				vals.push_back(out_value(r - 1, c, w, h));
		end
		// last pixel of the frame flushes the final row
		if (frame_last)
			for (int unsigned k = 0; k < w; k++)
				vals.push_back(line_copy[r % WIN][k]);
		foreach (vals[i]) begin
			item.pix = typed ? want : vals[i];
			item.last = (i == vals.size() - 1);
			item.fend = frame_last && (i == vals.size() - 1);
			filtered_q.push_back(item);
		end
		if (row_end) begin
			col_pos = '0;
			row_pos = frame_last ? '0 : row_pos + ROW_W'(1);
		end else begin
			col_pos = col_pos + COL_W'(1);
		end
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(255));
		endcase
	endfunction

	task automatic wait_drained();
		px_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_WIDTH: width_reg = data[COL_W-1:0];
			CFG_HEIGHT: height_reg = data;
			default: ;
		endcase
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [PIX_W-1:0] want,
			input bit typed);
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < send_gap_pct) begin
			px_valid <= 1'b0;
			@(posedge clk);
		end
		px_valid <= 1'b1;
		pixel_in <= pix;
		do @(posedge clk); while (px_stall);
		filter_pixel(pix, want, typed);
	endtask

	task automatic stream_frame();
		int unsigned total;
		total = eff_width() * eff_height();
		for (int unsigned k = 0; k < total; k++)
			send_pixel(rand_pixel(), '0, 1'b0);
	endtask

	task automatic run_frame(input logic [CFG_DATA_W-1:0] w_data,
			input logic [CFG_DATA_W-1:0] h_data);
		wait_drained();
		write_reg(CFG_WIDTH, w_data);
		write_reg(CFG_HEIGHT, h_data);
		stream_frame();
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (filtered_q.size() == 0) begin
				$display("%0t: pixel_out expected none actual %0d", $time, pixel_out);
				errors++;
			end else begin
				head = filtered_q.pop_front();
				if (pixel_out !== head.pix) begin
					$display("%0t: pixel_out expected %0d actual %0d", $time, head.pix,
						pixel_out);
					errors++;
				end
				if (run_last !== head.last) begin
					$display("%0t: run_last expected %0d actual %0d", $time, head.last,
						run_last);
					errors++;
				end
				if (frame_end !== head.fend) begin
					$display("%0t: frame_end expected %0d actual %0d", $time, head.fend,
						frame_end);
					errors++;
				end
			end
		end
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		logic [PIX_W-1:0] pix;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_tab[i]) begin
			if (directed_tab[i].kind == STEP_REG) begin
				wait_drained();
				write_reg(directed_tab[i].idx, directed_tab[i].data);
			end else begin
				for (int k = 0; k < directed_tab[i].count; k++) begin
					pix = directed_tab[i].pix;
					if (directed_tab[i].toggle && k[0])
						pix = ~pix;
					send_pixel(pix, pix, directed_tab[i].typed);
				end
			end
		end

		// no idling
		send_gap_pct = 0;
		stall_pct = 0;
		run_frame(12'd63, 12'd3);
		run_frame(12'd3, 12'd4);
		wait_drained();
		write_reg(CFG_SPARE_A, 12'h000);
		write_reg(CFG_SPARE_B, 12'hFFF);
		stream_frame();
		run_frame(CFG_DATA_W'($urandom_range(3, 5)), 12'd3);

		// sender idle
		send_gap_pct = 83;
		run_frame(12'd5, 12'd4);
		run_frame(12'hFC4, 12'd0);
		run_frame(12'd4, 12'd5);
		run_frame(CFG_DATA_W'($urandom_range(3, 5)), 12'd3);

		// receiver stalling
		send_gap_pct = 0;
		stall_pct = 83;
		run_frame(12'd6, 12'd4);
		run_frame(12'd2, 12'd1);
		run_frame(CFG_DATA_W'($urandom_range(3, 5)), 12'd3);

		// both sides
		send_gap_pct = 10;
		stall_pct = 10;
		run_frame(12'd7, 12'd4);
		run_frame(CFG_DATA_W'($urandom_range(3, 5)), 12'd3);

		wait_drained();
		if (errors == 0)
			$display("box_filter_3x3_tb: PASS");
		else
			$display("box_filter_3x3_tb: FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("box_filter_3x3_tb: FAIL");
		$finish;
	end

endmodule
